// ----- src/cba_pkg.sv -----
// Shared types and constants for the contiguous block allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cba_pkg;

    localparam int DEF_BLOCKS        = 1024;
    localparam int DEF_TABLE_ENTRIES = 32;
    localparam int DEF_ID_BITS       = 8;

    localparam logic [10:0] DISK_BLOCKS_RST = 11'd1024;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_PRELOAD = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NOSPACE  = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  file_id;
        logic [10:0] file_size;
        logic [9:0]  start_address;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] address;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DREAD,
        ST_DCMP,
        ST_SHIFT,
        ST_SHWR
    } state_t;

endpackage

// ----- src/contiguous_block_allocator.sv -----
// Top level of the contiguous block allocator: command FSM over the bitmap
// and file table memories. Depends on cba_pkg, cba_bitmap, cba_table.
`timescale 1ns / 1ps

// Usage
//   Request: drive request and pulse start; it is taken when start is high and
//   busy is low. One response follows, shown on result for one cycle with done
//   high; done cannot be held off, so the receiver must take it then.
//   Config: cfg_data (disk_blocks) is written when cfg_valid is high; cfg_ready
//   is always high. Write it only while no request is in flight.
// Sequence
//   create: the bitmap read port scans from start_address, one block per cycle,
//     for the first free run of file_size blocks; the run is then marked.
//   delete: searches the table entry by entry, frees the file's blocks, then
//     shifts later entries down. preload: marks its blocks. full / unused command: answered from idle.
//   One request at a time; busy stays high until the response is issued.
// Reset
//   After rst_n rises the bitmap is cleared one block per cycle, with busy high;
//   config writes are still taken then.
module contiguous_block_allocator
    import cba_pkg::*;
#(
    parameter int BLOCKS        = DEF_BLOCKS,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int ID_BITS       = DEF_ID_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output rsp_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int AW   = $clog2(BLOCKS);
    localparam int CW   = (AW + 1 > 12) ? AW + 1 : 12;
    localparam int TW   = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0]   BLOCKS_C = CW'(BLOCKS);
    localparam logic [CNTW-1:0] ENTRIES_C = CNTW'(TABLE_ENTRIES);

    state_t              state_reg, state_next;
    logic [10:0]         disk_reg;
    logic [CNTW-1:0]     count_reg, count_next;
    logic [CNTW-1:0]     idx_reg, idx_next;     // table search / shift index
    logic [CW-1:0]       cur_reg, cur_next;     // block pointer (clear, mark, issue)
    logic [CW-1:0]       end_reg, end_next;
    logic [CW-1:0]       pj_reg, pj_next;       // block whose bit arrives now
    logic                pv_reg, pv_next;
    logic [10:0]         run_reg, run_next;
    logic                val_reg, val_next;     // bit value being marked
    logic                del_reg, del_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [10:0]         size_reg, size_next;
    logic [9:0]          addr_reg, addr_next;
    logic                done_reg, done_next;
    rsp_t                res_reg, res_next;

    logic [CW-1:0]       n_use;
    logic [ID_BITS-1:0]  id_in;

    logic                bm_we, bm_wdata, bm_rdata;
    logic [AW-1:0]       bm_waddr, bm_raddr;
    logic                tb_we;
    logic [TW-1:0]       tb_waddr, tb_raddr;
    logic [ID_BITS-1:0]  tb_wid, tb_rid;
    logic [9:0]          tb_wstart, tb_rstart;
    logic [10:0]         tb_wlen, tb_rlen;

    cba_bitmap #(.BLOCKS(BLOCKS)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    cba_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .ID_BITS(ID_BITS)) u_table (
        .clk    (clk),
        .we     (tb_we),
        .waddr  (tb_waddr),
        .wid    (tb_wid),
        .wstart (tb_wstart),
        .wlen   (tb_wlen),
        .raddr  (tb_raddr),
        .rid    (tb_rid),
        .rstart (tb_rstart),
        .rlen   (tb_rlen)
    );

    // usable disk size, clipped to the bitmap
    assign n_use = (CW'(disk_reg) > BLOCKS_C) ? BLOCKS_C : CW'(disk_reg);
    assign id_in = ID_BITS'(request.file_id);

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            disk_reg  <= DISK_BLOCKS_RST;
            count_reg <= '0;
            cur_reg   <= '0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                disk_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        end_reg  <= end_next;
        pj_reg   <= pj_next;
        run_reg  <= run_next;
        val_reg  <= val_next;
        del_reg  <= del_next;
        id_reg   <= id_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        pj_next    = pj_reg;
        pv_next    = pv_reg;
        run_next   = run_reg;
        val_next   = val_reg;
        del_next   = del_reg;
        id_next    = id_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        bm_we     = 1'b0;
        bm_waddr  = cur_reg[AW-1:0];
        bm_wdata  = val_reg;
        bm_raddr  = cur_reg[AW-1:0];
        tb_we     = 1'b0;
        tb_waddr  = count_reg[TW-1:0];
        tb_wid    = id_reg;
        tb_wstart = addr_reg;
        tb_wlen   = size_reg;
        tb_raddr  = idx_reg[TW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                if (cur_reg < BLOCKS_C)
                begin
                    bm_we    = 1'b1;
                    bm_wdata = 1'b0;
                    cur_next = cur_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    id_next   = id_in;
                    size_next = request.file_size;
                    addr_next = request.start_address;
                    del_next  = 1'b0;
                    val_next  = 1'b1;
                    cur_next  = CW'(request.start_address);
                    end_next  = CW'(request.start_address) + CW'(request.file_size);
                    pv_next   = 1'b0;
                    run_next  = '0;
                    idx_next  = '0;
                    if (request.command == CMD_NONE)
                    begin
                        done_next = 1'b1;
                        res_next  = '{status: STS_NOTFOUND, address: '0};
                    end
                    else if (request.command == CMD_DELETE)
                    begin
                        state_next = ST_DREAD;
                    end
                    else if (count_reg >= ENTRIES_C)
                    begin
                        done_next = 1'b1;
                        res_next  = '{status: STS_FULL, address: '0};
                    end
                    else if (request.command == CMD_PRELOAD)
                    begin
                        tb_we      = 1'b1;
                        tb_wid     = id_in;
                        tb_wstart  = request.start_address;
                        tb_wlen    = request.file_size;
                        count_next = count_reg + 1'b1;
                        state_next = ST_MARK;
                    end
                    else if (request.file_size == '0)
                    begin
                        // empty file: placed at start unless beyond the disk end
                        if (CW'(request.start_address) > n_use)
                        begin
                            done_next = 1'b1;
                            res_next  = '{status: STS_NOSPACE, address: '0};
                        end
                        else
                        begin
                            tb_we      = 1'b1;
                            tb_wid     = id_in;
                            tb_wstart  = request.start_address;
                            tb_wlen    = request.file_size;
                            count_next = count_reg + 1'b1;
                            state_next = ST_MARK;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // bit for pj arrives while the next block is being read
                if (pv_reg && !bm_rdata &&
                    ({1'b0, run_reg} + 12'd1 == {1'b0, size_reg}))
                begin
                    tb_we      = 1'b1;
                    tb_wstart  = 10'(pj_reg + 1'b1 - CW'(size_reg));
                    addr_next  = 10'(pj_reg + 1'b1 - CW'(size_reg));
                    cur_next   = pj_reg + 1'b1 - CW'(size_reg);
                    end_next   = pj_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    pv_next    = 1'b0;
                    state_next = ST_MARK;
                end
                else
                begin
                    if (pv_reg)
                    begin
                        run_next = bm_rdata ? 11'd0 : run_reg + 11'd1;
                    end
                    if (cur_reg < n_use)
                    begin
                        bm_raddr = cur_reg[AW-1:0];
                        cur_next = cur_reg + 1'b1;
                        pj_next  = cur_reg;
                        pv_next  = 1'b1;
                    end
                    else
                    begin
                        pv_next = 1'b0;
                        if (!pv_reg)
                        begin
                            done_next  = 1'b1;
                            res_next   = '{status: STS_NOSPACE, address: '0};
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_MARK:
            begin
                if ((cur_reg < end_reg) && (cur_reg < BLOCKS_C))
                begin
                    bm_we    = 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
                else if (del_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    done_next  = 1'b1;
                    res_next   = '{status: STS_OK, address: addr_reg};
                    state_next = ST_IDLE;
                end
            end

            ST_DREAD:
            begin
                if (idx_reg < count_reg)
                begin
                    tb_raddr   = idx_reg[TW-1:0];
                    state_next = ST_DCMP;
                end
                else
                begin
                    done_next  = 1'b1;
                    res_next   = '{status: STS_NOTFOUND, address: '0};
                    state_next = ST_IDLE;
                end
            end

            ST_DCMP:
            begin
                if (tb_rid == id_reg)
                begin
                    cur_next   = CW'(tb_rstart);
                    end_next   = CW'(tb_rstart) + CW'(tb_rlen);
                    addr_next  = tb_rstart;
                    val_next   = 1'b0;
                    del_next   = 1'b1;
                    state_next = ST_MARK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DREAD;
                end
            end

            ST_SHIFT:
            begin
                // close the gap: entry idx+1 moves down to idx
                if (idx_reg + 1'b1 < count_reg)
                begin
                    tb_raddr   = TW'(idx_reg + 1'b1);
                    state_next = ST_SHWR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    res_next   = '{status: STS_OK, address: addr_reg};
                    state_next = ST_IDLE;
                end
            end

            ST_SHWR:
            begin
                tb_we      = 1'b1;
                tb_waddr   = idx_reg[TW-1:0];
                tb_wid     = tb_rid;
                tb_wstart  = tb_rstart;
                tb_wlen    = tb_rlen;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SHIFT;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a response only ends a request that was in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("response without a request");

    // the table never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ENTRIES_C)
        else $error("table count overflow");

    // failed requests report address zero
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != STS_OK) |-> result.address == '0)
        else $error("nonzero address on failure");

    // an accepted request that is not answered at once keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (state_next != ST_IDLE) |=> busy && !done)
        else $error("request dropped");

endmodule

// ----- src/cba_bitmap.sv -----
// Block occupancy bitmap: one write port, one read port, registered read data.
// Depends on cba_pkg.
`timescale 1ns / 1ps

module cba_bitmap
    import cba_pkg::*;
#(
    parameter int BLOCKS = DEF_BLOCKS
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(BLOCKS)-1:0] waddr,
    input  logic                      wdata,
    input  logic [$clog2(BLOCKS)-1:0] raddr,
    output logic                      rdata
);

    logic mem [BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/cba_table.sv -----
// File table memory: entries of id, start and length; registered read.
// Depends on cba_pkg.
`timescale 1ns / 1ps

module cba_table
    import cba_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int ID_BITS       = DEF_ID_BITS
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
    input  logic [ID_BITS-1:0]               wid,
    input  logic [9:0]                       wstart,
    input  logic [10:0]                      wlen,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
    output logic [ID_BITS-1:0]               rid,
    output logic [9:0]                       rstart,
    output logic [10:0]                      rlen
);

    logic [ID_BITS+20:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wid, wstart, wlen};
        end
        {rid, rstart, rlen} <= mem[raddr];
    end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for contiguous_block_allocator: directed table, full-table check, then random requests.
// Depends on cba_pkg and the allocator RTL; holds its own bitmap and file table predictor.
`timescale 1ns / 1ps

module testbench;
    import cba_pkg::*;

    localparam int NUM_BLOCKS  = 1024;
    localparam int NUM_ENTRIES = 32;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    typedef struct {
        logic [10:0] disk;
        int          count;
    } segment_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    // predictor state
    bit          used_map [NUM_BLOCKS];
    logic [7:0]  file_ids [NUM_ENTRIES];
    logic [9:0]  file_base [NUM_ENTRIES];
    logic [10:0] file_len [NUM_ENTRIES];
    int          files_held;
    logic [10:0] disk_size;

    rsp_t        pending_rsp [$];
    int          errors = 0;
    int          stall_cycles = 0;
    int          gap_pct;

    contiguous_block_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // set or clear a run, skipping blocks beyond the bitmap
    function automatic void paint_run(input int base, input int len, input bit v);
        for (int k = 0; k < len; k++)
        begin
            if (base + k >= NUM_BLOCKS)
                break;
            used_map[base + k] = v;
        end
    endfunction

    // first-fit search; returns -1 when no run fits below the usable disk end
    function automatic int first_fit(input int from, input int size);
        int n;
        int run;
        n   = (disk_size > NUM_BLOCKS) ? NUM_BLOCKS : int'(disk_size);
        run = 0;
        if (size == 0)
            return (from > n) ? -1 : from;
        for (int j = from; j < n; j++)
        begin
            if (used_map[j])
                run = 0;
            else
            begin
                run++;
                if (run == size)
                    return j + 1 - size;
            end
        end
        return -1;
    endfunction

    // apply one request to the predictor state and return the response
    function automatic rsp_t allocate_predict(input req_t rq);
        rsp_t r;
        int   p;
        r.status  = STS_NOTFOUND;
        r.address = '0;
        if (rq.command == CMD_CREATE || rq.command == CMD_PRELOAD)
        begin
            if (files_held >= NUM_ENTRIES)
                r.status = STS_FULL;
            else
            begin
                p = (rq.command == CMD_PRELOAD) ? int'(rq.start_address)
                                                : first_fit(rq.start_address, rq.file_size);
                if (p < 0)
                    r.status = STS_NOSPACE;
                else
                begin
                    paint_run(p, rq.file_size, 1'b1);
                    file_ids[files_held]  = rq.file_id;
                    file_base[files_held] = p[9:0];
                    file_len[files_held]  = rq.file_size;
                    files_held++;
                    r.status  = STS_OK;
                    r.address = p[9:0];
                end
            end
        end
        else if (rq.command == CMD_DELETE)
        begin
            for (int i = 0; i < files_held; i++)
            begin
                if (file_ids[i] == rq.file_id)
                begin
                    paint_run(file_base[i], file_len[i], 1'b0);
                    r.status  = STS_OK;
                    r.address = file_base[i];
                    // oldest match goes; close the gap to keep insertion order
                    for (int k = i; k + 1 < files_held; k++)
                    begin
                        file_ids[k]  = file_ids[k + 1];
                        file_base[k] = file_base[k + 1];
                        file_len[k]  = file_len[k + 1];
                    end
                    files_held--;
                    break;
                end
            end
        end
        return r;
    endfunction

    // drive one request from a falling edge, wait for it to be taken,
    // then maybe leave the start line low for a while
    task automatic issue_request(input req_t rq, input bit typed, input rsp_t want);
        rsp_t p;
        request = rq;
        start   = 1'b1;
        do
            @(posedge clk);
        while (busy);
        p = allocate_predict(rq);
        pending_rsp.insert(pending_rsp.size(), typed ? want : p);
        @(negedge clk);
        if ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // disk size write, only with nothing in flight
    task automatic write_disk_size(input logic [10:0] v);
        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        disk_size = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic req_t random_request();
        req_t rq;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 45)
            rq.command = CMD_CREATE;
        else if (pick < 80)
            rq.command = CMD_DELETE;
        else if (pick < 92)
            rq.command = CMD_PRELOAD;
        else
            rq.command = CMD_NONE;
        // mostly a small id pool so deletes find their files
        rq.file_id = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 15))
                                               : 8'($urandom_range(0, 255));
        pick = $urandom_range(99);
        if (pick < 70)
            rq.file_size = 11'($urandom_range(0, 24));
        else if (pick < 90)
            rq.file_size = 11'($urandom_range(25, 200));
        else if (pick < 97)
            rq.file_size = 11'($urandom_range(201, 1024));
        else
            rq.file_size = 11'($urandom_range(0, 2047));
        rq.start_address = ($urandom_range(1)) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(0, 300));
        return rq;
    endfunction

    // response checker: one result per done cycle, against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d address=%0d",
                         $time, result.status, result.address);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, result.status);
                    errors++;
                end
                if (result.address !== want.address)
                begin
                    $display("%0t: address expected %0d actual %0d",
                             $time, want.address, result.address);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken and no response
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows [];
        segment_t segments [];
        rsp_t     none;
        req_t     rq;
        int       n;

        none         = '0;
        gap_pct      = 14;
        start        = 1'b0;
        request      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = DISK_BLOCKS_RST;
        rst_n        = 1'b0;
        disk_size    = DISK_BLOCKS_RST;
        files_held   = 0;
        foreach (used_map[b])
            used_map[b] = 1'b0;

        dir_rows = '{
            // zero-length create right at the base
            '{'{CMD_CREATE,  8'd1,   11'd0,    10'd0},    1'b1, '{STS_OK,       10'd0}},
            // whole disk, run ends exactly at the disk end
            '{'{CMD_CREATE,  8'd2,   11'd1024, 10'd0},    1'b1, '{STS_OK,       10'd0}},
            '{'{CMD_CREATE,  8'd3,   11'd1,    10'd0},    1'b1, '{STS_NOSPACE,  10'd0}},
            '{'{CMD_DELETE,  8'd2,   11'd0,    10'd0},    1'b1, '{STS_OK,       10'd0}},
            '{'{CMD_DELETE,  8'd99,  11'd0,    10'd0},    1'b1, '{STS_NOTFOUND, 10'd0}},
            '{'{CMD_NONE,    8'd1,   11'd5,    10'd5},    1'b1, '{STS_NOTFOUND, 10'd0}},
            // preload running past the end of the bitmap
            '{'{CMD_PRELOAD, 8'd4,   11'd2047, 10'd1000}, 1'b1, '{STS_OK,       10'd1000}},
            '{'{CMD_CREATE,  8'd5,   11'd1,    10'd1023}, 1'b1, '{STS_NOSPACE,  10'd0}},
            '{'{CMD_DELETE,  8'd4,   11'd0,    10'd0},    1'b1, '{STS_OK,       10'd1000}},
            '{'{CMD_CREATE,  8'd6,   11'd0,    10'd1023}, 1'b1, '{STS_OK,       10'd1023}},
            '{'{CMD_CREATE,  8'd7,   11'd5,    10'd1020}, 1'b1, '{STS_NOSPACE,  10'd0}},
            '{'{CMD_CREATE,  8'd255, 11'd4,    10'd1020}, 1'b1, '{STS_OK,       10'd1020}},
            // duplicate ids: delete takes the oldest
            '{'{CMD_PRELOAD, 8'd9,   11'd3,    10'd10},   1'b0, none},
            '{'{CMD_CREATE,  8'd9,   11'd3,    10'd0},    1'b0, none},
            '{'{CMD_DELETE,  8'd9,   11'd0,    10'd0},    1'b0, none},
            '{'{CMD_CREATE,  8'd170, 11'd682,  10'd341},  1'b0, none},
            '{'{CMD_DELETE,  8'd170, 11'd0,    10'd0},    1'b0, none}
        };

        segments = '{
            '{11'd700,  140},
            '{11'd1,    25},
            '{11'd0,    25},
            '{11'd2047, 105},
            '{11'd1024, 105}
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            issue_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        // fill the table, then create and preload must report it full
        while (files_held < NUM_ENTRIES)
        begin
            rq = '{CMD_PRELOAD, 8'($urandom_range(0, 255)), 11'd0,
                   10'($urandom_range(0, 1023))};
            issue_request(rq, 1'b0, none);
        end
        issue_request('{CMD_CREATE,  8'd42, 11'd1, 10'd0}, 1'b1, '{STS_FULL, 10'd0});
        issue_request('{CMD_PRELOAD, 8'd42, 11'd1, 10'd0}, 1'b1, '{STS_FULL, 10'd0});

        n = 0;
        foreach (segments[s])
        begin
            write_disk_size(segments[s].disk);
            repeat (segments[s].count)
            begin
                gap_pct = (n < 150) ? 14 : (n < 300) ? 59 : 0;
                issue_request(random_request(), 1'b0, none);
                n++;
            end
        end

        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- contiguous_block_allocator.f -----
src/cba_pkg.sv
src/cba_bitmap.sv
src/cba_table.sv
src/contiguous_block_allocator.sv
sim/testbench.sv
